/* design/r16sort_pkg.sv */
package r16sort_pkg;

    localparam int WORD_W         = 31;
    localparam int SHIFT_W        = 6;
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int DIGIT_BITS_DEF = 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_CNT_SRC,
        S_CNT_RD,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_SCT_SRC,
        S_SCT_RD,
        S_SCT_WR,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PASS_START,
        DP_CLEAR,
        DP_SRC_RD,
        DP_CNT_RD,
        DP_COUNT_WR,
        DP_PFX_RD,
        DP_PFX_WR,
        DP_SCAT_WR,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic elem_last;
        logic rad_last;
        logic pass_needed;
    } t_dp_status;

endpackage

/* design/r16sort_dp.sv */
module r16sort_dp
    import r16sort_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WORD_W-1:0] i_value,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_sorted_value,
    output logic              o_last_out
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int RADIX = 1 << DIGIT_BITS;

    // ping-pong word buffers and the per-digit count/offset table
    logic [WORD_W-1:0]     r_buf0 [MAX_ITEMS];
    logic [WORD_W-1:0]     r_buf1 [MAX_ITEMS];
    logic [CNT_W-1:0]      r_cnt_mem [RADIX];

    logic [WORD_W-1:0]     r_rd_data;
    logic [CNT_W-1:0]      r_cnt_q;
    logic [CNT_W-1:0]      r_count;
    logic [WORD_W-1:0]     r_max;
    logic [SHIFT_W-1:0]    r_shift;
    logic                  r_sel;
    logic [IDX_W-1:0]      r_elem;
    logic [DIGIT_BITS-1:0] r_rad;
    logic [CNT_W-1:0]      r_sum;
    logic                  r_valid;
    logic                  r_last;

    logic [DIGIT_BITS-1:0] digit;
    logic                  full;
    logic                  elem_last;
    logic [IDX_W-1:0]      elem_next;

    logic                  buf_we;
    logic                  buf_wsel;
    logic [IDX_W-1:0]      buf_waddr;
    logic [WORD_W-1:0]     buf_wdata;
    logic                  buf_re;
    logic                  cnt_we;
    logic [DIGIT_BITS-1:0] cnt_waddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic                  cnt_re;
    logic [DIGIT_BITS-1:0] cnt_raddr;

    assign digit     = DIGIT_BITS'(r_rd_data >> r_shift);
    assign full      = (r_count == CNT_W'(MAX_ITEMS));
    assign elem_last = ((CNT_W'(r_elem) + CNT_W'(1)) == r_count);
    assign elem_next = elem_last ? '0 : r_elem + IDX_W'(1);

    assign o_status.elem_last   = elem_last;
    assign o_status.rad_last    = (r_rad == {DIGIT_BITS{1'b1}});
    assign o_status.pass_needed = (r_shift < SHIFT_W'(WORD_W)) && ((r_max >> r_shift) != '0);

    always_comb begin
        buf_we    = ((i_cmd.op == DP_LOAD) && !full) || (i_cmd.op == DP_SCAT_WR);
        buf_wsel  = (i_cmd.op == DP_LOAD) ? r_sel : ~r_sel;
        buf_waddr = (i_cmd.op == DP_LOAD) ? r_count[IDX_W-1:0] : r_cnt_q[IDX_W-1:0];
        buf_wdata = (i_cmd.op == DP_LOAD) ? i_value : r_rd_data;
        buf_re    = (i_cmd.op == DP_SRC_RD) || (i_cmd.op == DP_EMIT);

        cnt_we    = (i_cmd.op == DP_CLEAR) || (i_cmd.op == DP_PFX_WR) ||
                    (i_cmd.op == DP_COUNT_WR) || (i_cmd.op == DP_SCAT_WR);
        cnt_waddr = ((i_cmd.op == DP_CLEAR) || (i_cmd.op == DP_PFX_WR)) ? r_rad : digit;
        case (i_cmd.op)
            DP_CLEAR:  cnt_wdata = '0;
            DP_PFX_WR: cnt_wdata = r_sum;
            default:   cnt_wdata = r_cnt_q + CNT_W'(1);
        endcase
        cnt_re    = (i_cmd.op == DP_CNT_RD) || (i_cmd.op == DP_PFX_RD);
        cnt_raddr = (i_cmd.op == DP_PFX_RD) ? r_rad : digit;
    end

    always_ff @(posedge i_clk) begin
        if (buf_we && !buf_wsel) begin
            r_buf0[buf_waddr] <= buf_wdata;
        end
        if (buf_we && buf_wsel) begin
            r_buf1[buf_waddr] <= buf_wdata;
        end
        if (buf_re) begin
            r_rd_data <= r_sel ? r_buf1[r_elem] : r_buf0[r_elem];
        end
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_q <= r_cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= '0;
            r_shift <= '0;
            r_sel   <= 1'b0;
            r_elem  <= '0;
            r_rad   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == DP_EMIT);
            r_last  <= (i_cmd.op == DP_EMIT) && elem_last;
            case (i_cmd.op)
                DP_LOAD: begin
                    // drop words once the buffer is full
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                        if (i_value > r_max) begin
                            r_max <= i_value;
                        end
                    end
                end
                DP_PASS_START: begin
                    r_sum <= '0;
                end
                DP_CLEAR: begin
                    r_rad <= r_rad + DIGIT_BITS'(1);
                end
                DP_COUNT_WR: begin
                    r_elem <= elem_next;
                end
                DP_PFX_WR: begin
                    r_sum <= r_sum + r_cnt_q;
                    r_rad <= r_rad + DIGIT_BITS'(1);
                end
                DP_SCAT_WR: begin
                    r_elem <= elem_next;
                    // pass done: swap buffers, advance to the next digit
                    if (elem_last) begin
                        r_shift <= r_shift + SHIFT_W'(DIGIT_BITS);
                        r_sel   <= ~r_sel;
                    end
                end
                DP_EMIT: begin
                    r_elem <= elem_next;
                    if (elem_last) begin
                        r_count <= '0;
                        r_max   <= '0;
                        r_shift <= '0;
                        r_sel   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_sorted_value = r_rd_data;
    assign o_last_out     = r_last;

endmodule

/* design/r16sort_ctrl.sv */
module r16sort_ctrl
    import r16sort_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_last,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.pass_needed ? S_CLEAR : S_EMIT;
            end
            S_CLEAR: begin
                if (i_status.rad_last) begin
                    n_state = S_CNT_SRC;
                end
            end
            S_CNT_SRC: n_state = S_CNT_RD;
            S_CNT_RD:  n_state = S_CNT_WR;
            S_CNT_WR: begin
                n_state = i_status.elem_last ? S_PFX_RD : S_CNT_SRC;
            end
            S_PFX_RD:  n_state = S_PFX_WR;
            S_PFX_WR: begin
                n_state = i_status.rad_last ? S_SCT_SRC : S_PFX_RD;
            end
            S_SCT_SRC: n_state = S_SCT_RD;
            S_SCT_RD:  n_state = S_SCT_WR;
            S_SCT_WR: begin
                n_state = i_status.elem_last ? S_CHECK : S_SCT_SRC;
            end
            S_EMIT: begin
                if (i_status.elem_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = DP_NOP;
        o_busy   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.op = DP_LOAD;
                end
            end
            S_CHECK: begin
                if (i_status.pass_needed) begin
                    o_cmd.op = DP_PASS_START;
                end
            end
            S_CLEAR:   o_cmd.op = DP_CLEAR;
            S_CNT_SRC: o_cmd.op = DP_SRC_RD;
            S_CNT_RD:  o_cmd.op = DP_CNT_RD;
            S_CNT_WR:  o_cmd.op = DP_COUNT_WR;
            S_PFX_RD:  o_cmd.op = DP_PFX_RD;
            S_PFX_WR:  o_cmd.op = DP_PFX_WR;
            S_SCT_SRC: o_cmd.op = DP_SRC_RD;
            S_SCT_RD:  o_cmd.op = DP_CNT_RD;
            S_SCT_WR:  o_cmd.op = DP_SCAT_WR;
            S_EMIT:    o_cmd.op = DP_EMIT;
            default:   o_cmd.op = DP_NOP;
        endcase
    end

endmodule

/* design/radix16_lsd_sort_engine.sv */
// Stable LSD radix sort of up to MAX_ITEMS 31-bit words. While busy is low each
// start loads one word; words beyond MAX_ITEMS are dropped. A word with i_last
// set begins the sort, and busy stays high until the sorted run has been issued.
// The sort makes one digit pass per DIGIT_BITS-bit digit up to the highest set
// bit of the largest word. Each pass clears the count table, counts the digits,
// turns counts into offsets and scatters the words; each step handles one table
// entry or word at a time, as the count table and word buffers have a single
// write port and a registered read. Results then come out one per cycle on
// o_valid with o_last_out on the final word. The receiver cannot stall: each
// result is valid for that one cycle only and must be taken then.
module radix16_lsd_sort_engine
    import r16sort_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] i_value,
    input  logic              i_last,
    output logic              busy,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_sorted_value,
    output logic              o_last_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    r16sort_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_last),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    r16sort_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out)
    );

    // results only come out of a sort in progress
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // a final word always starts the sort
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("sort did not start after the final word");

    // nothing follows the end of the run
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |=> !o_valid)
        else $error("result transfer after the final word");

    // the final result releases the engine
    a_idle_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |-> !busy)
        else $error("engine still busy after the final result");

endmodule

/* sim/tb_radix16_lsd_sort_engine.sv */
`timescale 1ns / 1ps

module tb_radix16_lsd_sort_engine
    import r16sort_pkg::*;
();

    localparam int CAPACITY     = MAX_ITEMS_DEF;
    localparam int RADIX        = 1 << DIGIT_BITS_DEF;
    localparam int RANDOM_WORDS = 150;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last_out;
    } t_sorted_word;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
        logic              typed;
        logic [WORD_W-1:0] want;
    } t_load_row;

    localparam int DIR_ROWS = 21;
    localparam t_load_row LOAD_TABLE [0:DIR_ROWS-1] = '{
        // lone zero right after reset: no digit pass at all
        '{31'h0000_0000, 1'b1, 1'b1, 31'h0000_0000},
        // all-zero set comes back unchanged
        '{31'h0000_0000, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0000, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0000, 1'b1, 1'b0, 31'h0},
        '{31'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFF},
        '{31'h0000_0001, 1'b1, 1'b1, 31'h0000_0001},
        '{31'h7FFF_FFFF, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0000, 1'b0, 1'b0, 31'h0},
        '{31'h4000_0000, 1'b0, 1'b0, 31'h0},
        '{31'h0000_000F, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0010, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0001, 1'b1, 1'b0, 31'h0},
        // equal low digits, split by the next digit
        '{31'h0000_0021, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0012, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0021, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0011, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0002, 1'b0, 1'b0, 31'h0},
        '{31'h0000_0020, 1'b1, 1'b0, 31'h0},
        '{31'h5555_5555, 1'b0, 1'b0, 31'h0},
        '{31'h2AAA_AAAA, 1'b1, 1'b0, 31'h0},
        '{31'h0F00_0000, 1'b1, 1'b1, 31'h0F00_0000}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic [WORD_W-1:0] i_value;
    logic              i_last;
    logic              busy;
    logic              o_valid;
    logic [WORD_W-1:0] o_sorted_value;
    logic              o_last_out;

    radix16_lsd_sort_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_value        (i_value),
        .i_last         (i_last),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out)
    );

    // predictor state
    logic [WORD_W-1:0] held_words [CAPACITY];
    int                held_count;
    logic [WORD_W-1:0] peak_word;
    t_sorted_word      fresh_run [$];

    t_sorted_word      sorted_expect [$];
    t_sorted_word      head_word;
    int                mismatches;
    int                cycles;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (sorted_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h last %b", o_sorted_value, o_last_out);
            end else begin
                head_word = sorted_expect.pop_front();
                if (o_sorted_value !== head_word.value || o_last_out !== head_word.last_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h last %b, got %h last %b",
                                 head_word.value, head_word.last_out,
                                 o_sorted_value, o_last_out);
                end
            end
        end
    end

    // Store one word; on the last flag run the digit passes and fill fresh_run.
    task automatic absorb_word(input logic [WORD_W-1:0] v, input logic l);
        logic [WORD_W-1:0] scatter [CAPACITY];
        int                tally [RADIX];
        int                slot [RADIX];
        int                shift;
        int                sum;
        int                d;
        fresh_run.delete();
        if (held_count < CAPACITY) begin
            held_words[held_count] = v;
            held_count++;
            if (v > peak_word)
                peak_word = v;
        end
        if (!l)
            return;
        shift = 0;
        while (shift < WORD_W && (peak_word >> shift) != 0) begin
            for (int k = 0; k < RADIX; k++)
                tally[k] = 0;
            for (int k = 0; k < held_count; k++)
                tally[(held_words[k] >> shift) & (RADIX - 1)]++;
            sum = 0;
            for (int k = 0; k < RADIX; k++) begin
                slot[k] = sum;
                sum += tally[k];
            end
            for (int k = 0; k < held_count; k++) begin
                d = (held_words[k] >> shift) & (RADIX - 1);
                scatter[slot[d]] = held_words[k];
                slot[d]++;
            end
            for (int k = 0; k < held_count; k++)
                held_words[k] = scatter[k];
            shift += DIGIT_BITS_DEF;
        end
        for (int k = 0; k < held_count; k++)
            fresh_run.push_back('{held_words[k], k == held_count - 1});
        held_count = 0;
        peak_word  = '0;
    endtask

    // Called at a falling edge; leaves start high so back-to-back transfers need no dip.
    task automatic send_word(input logic [WORD_W-1:0] v, input logic l);
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        absorb_word(v, l);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word(input int flavor);
        int w;
        case (flavor)
            0: return WORD_W'($urandom);
            1: begin
                w = $urandom_range(0, WORD_W);
                return (w == 0) ? '0 : WORD_W'($urandom >> (32 - w));
            end
            default: return WORD_W'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        int               sent;
        int               set_size;
        int               set_index;
        int               flavor;
        bit               quiet;
        logic [WORD_W-1:0] v;

        start      = 1'b0;
        i_value    = '0;
        i_last     = 1'b0;
        i_rst_n    = 1'b0;
        held_count = 0;
        peak_word  = '0;
        mismatches = 0;
        cycles     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_word(LOAD_TABLE[r].value, LOAD_TABLE[r].last);
            if (LOAD_TABLE[r].typed)
                sorted_expect.push_back('{LOAD_TABLE[r].want, 1'b1});
            else
                foreach (fresh_run[k]) sorted_expect.push_back(fresh_run[k]);
            idle_for(pick_gap());
        end

        // hold off until the directed runs have fully drained
        start <= 1'b0;
        while (sorted_expect.size() != 0) @(negedge i_clk);
        @(negedge i_clk);

        sent      = 0;
        set_index = 0;
        while (sent < RANDOM_WORDS) begin
            // one set overruns the buffer: its final two words are dropped,
            // and the last flag on the final one still starts the sort
            set_size = (set_index == 3) ? CAPACITY + 2 : $urandom_range(1, 8);
            flavor   = $urandom_range(0, 2);
            quiet    = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_size; k++) begin
                v = pick_word(flavor);
                send_word(v, k == set_size - 1);
                foreach (fresh_run[j]) sorted_expect.push_back(fresh_run[j]);
                sent++;
                if (!quiet)
                    idle_for(pick_gap());
            end
            set_index++;
        end

        start <= 1'b0;
        while (sorted_expect.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && sorted_expect.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
